### rtl/core/ect_pkg.sv
// types, codes and character classes for the expression character tokenizer
`default_nettype none

package ect_pkg;

    // scan modes, one-hot
    typedef enum logic [8:0] {
        MODE_IDLE      = 9'b0_0000_0001,
        MODE_IDENT     = 9'b0_0000_0010,
        MODE_NUM_FIRST = 9'b0_0000_0100,
        MODE_NUM       = 9'b0_0000_1000,
        MODE_REAL      = 9'b0_0001_0000,
        MODE_HEX       = 9'b0_0010_0000,
        MODE_PCT       = 9'b0_0100_0000,
        MODE_MARKER    = 9'b0_1000_0000,
        MODE_ERROR     = 9'b1_0000_0000
    } mode_t;

    // token kinds
    localparam logic [5:0] KIND_IDENT      = 6'd0;
    localparam logic [5:0] KIND_DEC        = 6'd1;
    localparam logic [5:0] KIND_REAL       = 6'd2;
    localparam logic [5:0] KIND_HEX        = 6'd3;
    localparam logic [5:0] KIND_MARKER     = 6'd4;
    localparam logic [5:0] KIND_PERCENT    = 6'd5;
    localparam logic [5:0] KIND_ATOM0      = 6'd6;
    localparam logic [5:0] KIND_END        = 6'd37;
    localparam logic [5:0] KIND_UNEXPECTED = 6'd38;
    localparam logic [5:0] KIND_NONE       = 6'd63;

    // characters with a role of their own
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one closed token
    typedef struct packed {
        logic        last;
        logic [15:0] length;
        logic [15:0] column;
        logic [15:0] line;
        logic [15:0] offset;
        logic [5:0]  kind;
    } tok_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    // punctuation atom kind, or KIND_NONE for a byte that is no atom
    function automatic logic [5:0] atom_kind(input logic [7:0] c);
        logic [5:0] k;
        k = KIND_NONE;
        if (c inside {[8'h21:8'h24]})
            k = KIND_ATOM0 + 6'(c - 8'h21);
        else if (c inside {[8'h26:8'h2F]})
            k = KIND_ATOM0 + 6'(c - 8'h22);
        else if (c inside {[8'h3A:8'h40]})
            k = KIND_ATOM0 + 6'(c - 8'h2C);
        else if (c inside {[8'h5B:8'h60]})
            k = KIND_ATOM0 + 6'(c - 8'h46);
        else if (c inside {[8'h7B:8'h7E]})
            k = KIND_ATOM0 + 6'(c - 8'h60);
        return k;
    endfunction

endpackage

`default_nettype wire

### rtl/core/expression_char_tokenizer.sv
// top level: byte stream tokenizer with a small result queue
// a closed token is written to the result queue and shows on m_tdata from its head
// throughput: one text byte per cycle; a beat that closes one token and
// opens an atom, end or error gives two results, drained one per cycle with m_tready
// high, through a four-entry result queue (s_tready drops while it holds three or more)
// reset: asynchronous; mode idle, all counters zero, queue empty
`default_nettype none

module expression_char_tokenizer
    import ect_pkg::*;
#(
    parameter longint unsigned MAX_TEXT_LENGTH = 65535
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // text_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // start_offset, start_line, start_column, token_length
    output logic [5:0]       m_tuser,   // token_kind
    output logic             m_tlast    // last_of_text
);

    localparam logic [15:0] COUNT_CAP =
        (MAX_TEXT_LENGTH > 64'd65535) ? 16'hFFFF : 16'(MAX_TEXT_LENGTH);

    function automatic logic [15:0] sat_inc(input logic [15:0] x);
        return (x < COUNT_CAP) ? x + 16'd1 : x;
    endfunction

    // scan state
    mode_t       mode_reg, mode_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] column_reg, column_next;
    logic [15:0] open_offset_reg, open_offset_next;
    logic [15:0] open_line_reg, open_line_next;
    logic [15:0] open_column_reg, open_column_next;
    logic [15:0] open_length_reg, open_length_next;

    // result queue
    tok_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic        in_fire, out_fire;
    logic [7:0]  c;
    logic [15:0] adv_offset, adv_line, adv_column;
    logic [5:0]  atom;
    tok_t        res_a, res_b, push_first;
    logic        res_a_vld, res_b_vld;
    logic [1:0]  push_num;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign c        = s_tdata;
    assign atom     = atom_kind(c);

    // counters after this byte is consumed
    assign adv_offset = sat_inc(offset_reg);
    assign adv_line   = (c == CH_NL) ? sat_inc(line_reg) : line_reg;
    assign adv_column = (c == CH_NL) ? 16'd0 : sat_inc(column_reg);

    // mode update and token results for one beat
    always_comb
    begin
        logic rescan;
        logic extend;
        rescan           = 1'b0;
        extend           = 1'b0;
        mode_next        = mode_reg;
        offset_next      = offset_reg;
        line_next        = line_reg;
        column_next      = column_reg;
        open_offset_next = open_offset_reg;
        open_line_next   = open_line_reg;
        open_column_next = open_column_reg;
        open_length_next = open_length_reg;
        res_a_vld        = 1'b0;
        res_b_vld        = 1'b0;
        res_a            = '{last: 1'b0, length: open_length_reg, column: open_column_reg,
                             line: open_line_reg, offset: open_offset_reg, kind: KIND_IDENT};
        res_b            = '{last: 1'b0, length: 16'd1, column: column_reg,
                             line: line_reg, offset: offset_reg, kind: KIND_END};

        if (in_fire)
        begin
            case (mode_reg)
                MODE_ERROR:
                begin
                    if (c == CH_NUL)
                    begin
                        offset_next = 16'd0;
                        line_next   = 16'd0;
                        column_next = 16'd0;
                        mode_next   = MODE_IDLE;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c) || c == CH_UNDER)
                        extend = 1'b1;
                    else
                    begin
                        res_a_vld  = 1'b1;
                        res_a.kind = KIND_IDENT;
                        rescan     = 1'b1;
                    end
                end
                MODE_NUM_FIRST, MODE_NUM:
                begin
                    if (mode_reg == MODE_NUM_FIRST && (c == CH_LOW_X || c == CH_UP_X))
                    begin
                        mode_next = MODE_HEX;
                        extend    = 1'b1;
                    end
                    else if (is_digit(c))
                    begin
                        mode_next = MODE_NUM;
                        extend    = 1'b1;
                    end
                    else if (c == CH_DOT)
                    begin
                        mode_next = MODE_REAL;
                        extend    = 1'b1;
                    end
                    else
                    begin
                        res_a_vld  = 1'b1;
                        res_a.kind = KIND_DEC;
                        rescan     = 1'b1;
                    end
                end
                MODE_REAL:
                begin
                    if (is_digit(c))
                        extend = 1'b1;
                    else
                    begin
                        res_a_vld  = 1'b1;
                        res_a.kind = KIND_REAL;
                        rescan     = 1'b1;
                    end
                end
                MODE_HEX:
                begin
                    if (is_xdigit(c))
                        extend = 1'b1;
                    else
                    begin
                        res_a_vld  = 1'b1;
                        res_a.kind = KIND_HEX;
                        rescan     = 1'b1;
                    end
                end
                MODE_MARKER:
                begin
                    if (is_digit(c))
                        extend = 1'b1;
                    else
                    begin
                        res_a_vld  = 1'b1;
                        res_a.kind = KIND_MARKER;
                        rescan     = 1'b1;
                    end
                end
                MODE_PCT:
                begin
                    if (is_digit(c))
                    begin
                        // marker covers the digits only
                        mode_next        = MODE_MARKER;
                        open_offset_next = offset_reg;
                        open_line_next   = line_reg;
                        open_column_next = column_reg;
                        open_length_next = 16'd1;
                        offset_next      = adv_offset;
                        line_next        = adv_line;
                        column_next      = adv_column;
                    end
                    else if (c == CH_PERCENT)
                    begin
                        // double percent: atom at the second one
                        res_a_vld    = 1'b1;
                        res_a.kind   = KIND_PERCENT;
                        res_a.offset = offset_reg;
                        res_a.line   = line_reg;
                        res_a.column = column_reg;
                        res_a.length = 16'd1;
                        offset_next  = adv_offset;
                        line_next    = adv_line;
                        column_next  = adv_column;
                        mode_next    = MODE_IDLE;
                    end
                    else
                    begin
                        res_a_vld        = 1'b1;
                        res_a.kind       = KIND_PERCENT;
                        res_a.length     = 16'd1;
                        open_length_next = 16'd1;
                        rescan           = 1'b1;
                    end
                end
                default:
                    rescan = 1'b1;
            endcase

            // grow the open token
            if (extend)
            begin
                open_length_next = sat_inc(open_length_reg);
                offset_next      = adv_offset;
                line_next        = adv_line;
                column_next      = adv_column;
            end

            // byte scanned afresh from idle
            if (rescan)
            begin
                mode_next = MODE_IDLE;
                if (c == CH_NUL)
                begin
                    res_b_vld   = 1'b1;
                    res_b.kind  = KIND_END;
                    res_b.last  = 1'b1;
                    offset_next = 16'd0;
                    line_next   = 16'd0;
                    column_next = 16'd0;
                end
                else if (is_space(c))
                begin
                    offset_next = adv_offset;
                    line_next   = adv_line;
                    column_next = adv_column;
                end
                else if (is_alpha(c) || is_digit(c) || c == CH_PERCENT)
                begin
                    if (is_alpha(c))
                        mode_next = MODE_IDENT;
                    else if (is_digit(c))
                        mode_next = MODE_NUM_FIRST;
                    else
                        mode_next = MODE_PCT;
                    open_offset_next = offset_reg;
                    open_line_next   = line_reg;
                    open_column_next = column_reg;
                    open_length_next = 16'd1;
                    offset_next      = adv_offset;
                    line_next        = adv_line;
                    column_next      = adv_column;
                end
                else if (atom != KIND_NONE)
                begin
                    res_b_vld   = 1'b1;
                    res_b.kind  = atom;
                    offset_next = adv_offset;
                    line_next   = adv_line;
                    column_next = adv_column;
                end
                else
                begin
                    res_b_vld  = 1'b1;
                    res_b.kind = KIND_UNEXPECTED;
                    res_b.last = 1'b1;
                    mode_next  = MODE_ERROR;
                end
            end
        end
    end

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            offset_reg      <= '0;
            line_reg        <= '0;
            column_reg      <= '0;
            open_offset_reg <= '0;
            open_line_reg   <= '0;
            open_column_reg <= '0;
            open_length_reg <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            offset_reg      <= offset_next;
            line_reg        <= line_next;
            column_reg      <= column_next;
            open_offset_reg <= open_offset_next;
            open_line_reg   <= open_line_next;
            open_column_reg <= open_column_next;
            open_length_reg <= open_length_next;
        end
    end

    // queue push: closed token first, then the fresh result
    assign push_num   = {1'b0, res_a_vld} + {1'b0, res_b_vld};
    assign push_first = res_a_vld ? res_a : res_b;
    assign count_next = count_reg + QCNT_W'(push_num) - QCNT_W'(out_fire);

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
            queue_reg[wr_ptr_reg] <= push_first;
        if (push_num == 2'd2)
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_num);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(out_fire);
            count_reg  <= count_next;
        end
    end

    // port side
    assign s_tready = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {queue_reg[rd_ptr_reg].length, queue_reg[rd_ptr_reg].column,
                       queue_reg[rd_ptr_reg].line, queue_reg[rd_ptr_reg].offset};
    assign m_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode_reg == MODE_ERROR && s_tdata != CH_NUL) |=> mode_reg == MODE_ERROR)
        else $error("error mode left before end of text");

    a_nul_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tdata == CH_NUL) |=>
            (offset_reg == 16'd0 && line_reg == 16'd0 && column_reg == 16'd0
             && mode_reg == MODE_IDLE))
        else $error("end of text did not rewind counters");

    a_drain_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !in_fire) |=> count_reg == $past(count_reg) - QCNT_W'(1))
        else $error("queue count wrong on pop");

endmodule

`default_nettype wire
